// File: rtl/tcse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcse_pkg;

  localparam int MemDepth = 256;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int RegCount = 16;
  localparam int RegAw    = 4;

  localparam logic [2:0] REQ_STEP    = 3'd0;
  localparam logic [2:0] REQ_MEM_WR  = 3'd1;
  localparam logic [2:0] REQ_MEM_RD  = 3'd2;
  localparam logic [2:0] REQ_REG_RD  = 3'd3;
  localparam logic [2:0] REQ_RESTART = 3'd4;

  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_LDI   = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADDI  = 4'h5;
  localparam logic [3:0] OP_ADDF  = 4'h6;
  localparam logic [3:0] OP_OR    = 4'h7;
  localparam logic [3:0] OP_AND   = 4'h8;
  localparam logic [3:0] OP_XOR   = 4'h9;
  localparam logic [3:0] OP_ROR   = 4'hA;
  localparam logic [3:0] OP_JMP   = 4'hB;
  localparam logic [3:0] OP_HALT  = 4'hC;
  localparam logic [3:0] OP_ROL   = 4'hD;

  // Memory port operation chosen by the controller each cycle.
  typedef enum logic [2:0] {
    MOP_NONE  = 3'd0,
    MOP_REQ   = 3'd1, // read at request addr
    MOP_WRREQ = 3'd2, // write wdata at request addr
    MOP_PC0   = 3'd3, // read at pc
    MOP_PC1   = 3'd4, // read at pc+1
    MOP_B1    = 3'd5  // read or store at b1
  } mem_op_t;

  typedef struct packed {
    logic     load_req;   // capture request beat
    mem_op_t  mem_op;
    logic     cap_b0;
    logic     cap_b1;
    logic     exec;       // never set; a step's instruction runs on finish
    logic     finish;     // load result register, run a step's instruction
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       can_run;
    logic [3:0] opcode;
  } dp_stat_t;

  function automatic logic [7:0] float_add(input logic [7:0] a, input logic [7:0] b);
    logic [11:0] ma, mb;
    logic [12:0] mag;
    logic        sgn;
    logic [7:0]  res;
    ma = 12'(a[3:0]) << a[6:4];
    mb = 12'(b[3:0]) << b[6:4];
    if (a[7] == b[7]) begin
      mag = {1'b0, ma} + {1'b0, mb};
      sgn = a[7];
    end else if (ma >= mb) begin
      mag = {1'b0, ma - mb};
      sgn = a[7];
    end else begin
      mag = {1'b0, mb - ma};
      sgn = b[7];
    end
    res = 8'h00;
    if (mag == 13'd0) res = 8'h00;
    else if (mag[12:11] != 2'b00) res = {sgn, 7'h7F};
    else begin
      res = {sgn, 3'd7, mag[10:7]};
      for (int e = 6; e >= 0; e--) begin
        if ((mag >> e) <= 13'd15) res = {sgn, 3'(e), 4'(mag >> e)};
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/tcse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tcse_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  wire tcse_pkg::dp_stat_t stat,
  output tcse_pkg::dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DISP  = 6'b000010,
    S_FET1  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mem_op = tcse_pkg::MOP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.load_req = 1'b1;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        if (stat.req_type == tcse_pkg::REQ_STEP && stat.can_run) begin
          cmd.mem_op = tcse_pkg::MOP_PC0;
          state_next = S_FET1;
        end else begin
          if (stat.req_type == tcse_pkg::REQ_MEM_WR) cmd.mem_op = tcse_pkg::MOP_WRREQ;
          state_next = S_DONE;
        end
      end
      S_FET1: begin
        cmd.cap_b0 = 1'b1;
        cmd.mem_op = tcse_pkg::MOP_PC1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.cap_b1 = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // b1 is registered; data-memory op of a step happens here,
        // a memory read request reads here so its byte is ready in S_OUT
        if (stat.req_type == tcse_pkg::REQ_STEP && stat.can_run)
          cmd.mem_op = tcse_pkg::MOP_B1;
        else if (stat.req_type == tcse_pkg::REQ_MEM_RD)
          cmd.mem_op = tcse_pkg::MOP_REQ;
        cmd.exec   = 1'b0;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.finish = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // a step runs on finish, in the cycle after the B1 access, so load data is on the read register
    if (state == S_OUT) cmd.exec = 1'b0;
  end

endmodule
`default_nettype wire

// File: rtl/tcse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tcse_datapath (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_valid,
  input  wire  [7:0]              cfg_data,
  input  wire  [2:0]              req_type,
  input  wire  [7:0]              addr,
  input  wire  [7:0]              wdata,
  input  wire tcse_pkg::dp_cmd_t  cmd,
  output tcse_pkg::dp_stat_t      stat,
  output logic [7:0]              read_data,
  output logic [8:0]              prog_counter,
  output logic                    halted,
  output logic [15:0]             last_instr
);

  logic [7:0] mem [tcse_pkg::MemDepth];
  logic [tcse_pkg::MemDepth-1:0] mem_vld;
  logic [7:0] regs [tcse_pkg::RegCount];
  logic [8:0] pc;
  logic       hflag;
  logic [7:0] boot_addr;
  logic [2:0] rq;
  logic [7:0] ra, rw;
  logic [7:0] b0, b1;
  logic [7:0] mrd;
  logic       mrd_ok;
  logic       executed;
  logic       ran;   // set when this item fetches an instruction (running step)

  // memory address and operation
  logic [8:0] maddr;
  logic       mwe, mre;
  logic [7:0] mwd;
  always_comb begin
    maddr = 9'd0; mwe = 1'b0; mre = 1'b0; mwd = rw;
    unique case (cmd.mem_op)
      tcse_pkg::MOP_REQ:   begin maddr = {1'b0, ra}; mre = 1'b1; end
      tcse_pkg::MOP_WRREQ: begin maddr = {1'b0, ra}; mwe = 1'b1; end
      tcse_pkg::MOP_PC0:   begin maddr = pc; mre = 1'b1; end
      tcse_pkg::MOP_PC1:   begin maddr = pc + 9'd1; mre = 1'b1; end
      tcse_pkg::MOP_B1: begin
        maddr = {1'b0, b1};
        mre = (b0[7:4] == tcse_pkg::OP_LOAD);
        mwe = (b0[7:4] == tcse_pkg::OP_STORE);
        mwd = regs[b0[3:0]];
      end
      default: ;
    endcase
  end

  wire in_range = (maddr < 9'(tcse_pkg::MemDepth));
  wire [tcse_pkg::MemAw-1:0] mi = maddr[tcse_pkg::MemAw-1:0];

  always_ff @(posedge clk) begin
    if (mwe && in_range) mem[mi] <= mwd;
    mrd <= mem[mi];
  end
  always_ff @(posedge clk) begin
    if (rst) mrd_ok <= 1'b0;
    else     mrd_ok <= mre && in_range && mem_vld[mi];
  end
  always_ff @(posedge clk) begin
    if (rst) mem_vld <= '0;
    else if (mwe && in_range) mem_vld[mi] <= 1'b1;
  end
  wire [7:0] mdata = mrd_ok ? mrd : 8'h00;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin rq <= req_type; ra <= addr; rw <= wdata; end
    if (cmd.cap_b0) b0 <= mdata;
    if (cmd.cap_b1) b1 <= mdata;
  end

  assign stat.req_type = rq;
  assign stat.can_run  = !hflag && (pc < 9'(tcse_pkg::MemDepth));
  assign stat.opcode   = b0[7:4];

  // execute in the first cycle of the result state (load data is in mdata then)
  logic [7:0] rs, rt, rr, r0, rot_in;
  logic [2:0] rn;
  logic [8:0] nxt;
  always_comb begin
    rs = regs[b1[7:4]]; rt = regs[b1[3:0]]; rr = regs[b0[3:0]]; r0 = regs[0];
    nxt = (pc + 9'd2 > 9'd256) ? 9'd256 : pc + 9'd2;
    rn = (b0[7:4] == tcse_pkg::OP_ROL) ? 3'(4'd8 - {1'b0, b1[2:0]}) : b1[2:0];
    rot_in = rr;
  end
  wire [15:0] dbl = {rot_in, rot_in};
  wire [7:0]  rot = 8'(dbl >> rn);

  wire do_exec = cmd.finish && !executed && rq == tcse_pkg::REQ_STEP && ran;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 9'd0; hflag <= 1'b0; boot_addr <= 8'd0; executed <= 1'b0;
      ran <= 1'b0;
      for (int i = 0; i < tcse_pkg::RegCount; i++) regs[i] <= 8'd0;
    end else begin
      if (cfg_valid) boot_addr <= cfg_data;
      if (cmd.cap_b0) ran <= 1'b1;
      if (cmd.load_req) begin executed <= 1'b0; ran <= 1'b0; end
      if (cmd.finish && !executed) begin
        executed <= 1'b1;
        if (rq == tcse_pkg::REQ_RESTART) begin
          pc <= {1'b0, boot_addr}; hflag <= 1'b0;
        end
      end
      if (do_exec) begin
        pc <= nxt;
        unique case (b0[7:4])
          tcse_pkg::OP_LOAD:  regs[b0[3:0]] <= mdata;
          tcse_pkg::OP_LDI:   regs[b0[3:0]] <= b1;
          tcse_pkg::OP_MOVE:  regs[b1[3:0]] <= rs;
          tcse_pkg::OP_ADDI:  regs[b0[3:0]] <= rs + rt;
          tcse_pkg::OP_ADDF:  regs[b0[3:0]] <= tcse_pkg::float_add(rs, rt);
          tcse_pkg::OP_OR:    regs[b0[3:0]] <= rs | rt;
          tcse_pkg::OP_AND:   regs[b0[3:0]] <= rs & rt;
          tcse_pkg::OP_XOR:   regs[b0[3:0]] <= rs ^ rt;
          tcse_pkg::OP_ROR,
          tcse_pkg::OP_ROL:   regs[b0[3:0]] <= rot;
          tcse_pkg::OP_JMP:   if (r0 == rr) pc <= {1'b0, b1};
          tcse_pkg::OP_HALT:  hflag <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // outputs are read while the result beat is held; values after execution
  logic [7:0] rd_q;
  always_ff @(posedge clk) begin
    if (cmd.finish && !executed) begin
      rd_q <= (rq == tcse_pkg::REQ_MEM_RD) ? mdata
            : (rq == tcse_pkg::REQ_REG_RD) ? regs[ra[3:0]] : 8'h00;
    end
  end

  assign read_data    = rd_q;
  assign prog_counter = pc;
  assign halted       = hflag || (pc >= 9'(tcse_pkg::MemDepth));
  assign last_instr   = (rq == tcse_pkg::REQ_STEP && ran) ? {b0, b1} : 16'h0000;

endmodule
`default_nettype wire

// File: rtl/toy_cpu_step_executor.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid/in_ready    req_type, addr, wdata
// out       out_valid/out_ready  read_data, prog_counter, halted, last_instr
// cfg       cfg_valid/cfg_ready  cfg_data (boot address)
//
// One request beat at a time: accept, dispatch, fetch of b0 and b1 for a running
// step, a data-memory access, then a settle step before the result beat shows.
// A running step passes through both fetch states; any other request (a stopped
// step too) skips them, and out_ready can stall the result beat.
// in_ready rises the cycle after the result beat is taken.
// The single-port 256-byte memory sets the order: fetch b0, b1, then data access.
// rst is synchronous; memory reads as zero until written (per-byte valid).
module toy_cpu_step_executor (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  req_type,
  input  wire  [7:0]  addr,
  input  wire  [7:0]  wdata,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  read_data,
  output logic [8:0]  prog_counter,
  output logic        halted,
  output logic [15:0] last_instr,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data
);

  tcse_pkg::dp_cmd_t  cmd;
  tcse_pkg::dp_stat_t stat;
  logic out_valid_i;

  assign cfg_ready = 1'b1;

  // Result beat is presented in the cycle after the controller enters its result state.
  logic shown;
  always_ff @(posedge clk) begin
    if (rst) shown <= 1'b0;
    else     shown <= out_valid_i && !(shown && out_ready);
  end
  assign out_valid = out_valid_i && shown;

  // controller leaves the result state only on a real output beat
  tcse_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid(out_valid_i),
    .out_ready(out_ready && shown), .stat, .cmd
  );

  tcse_datapath u_dp (
    .clk, .rst, .cfg_valid, .cfg_data, .req_type, .addr, .wdata, .cmd,
    .stat, .read_data, .prog_counter, .halted, .last_instr
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in and out both open");
  a_halt_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (halted || prog_counter < 9'd256)) else $error("halted mismatch");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    prog_counter <= 9'd256) else $error("pc out of range");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_toy_cpu_step_executor.sv
`timescale 1ns / 1ps
module tb_toy_cpu_step_executor;

  // One request beat and its predicted result beat.
  typedef struct {
    logic [2:0] req_type;
    logic [7:0] addr;
    logic [7:0] wdata;
  } req_t;

  typedef struct {
    logic [7:0]  read_data;
    logic [8:0]  prog_counter;
    logic        halted;
    logic [15:0] last_instr;
  } res_t;

  // request codes with no function
  localparam logic [2:0] ReqSpareLo = 3'd5;
  localparam logic [2:0] ReqSpareHi = 3'd7;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  req_type;
  logic [7:0]  addr;
  logic [7:0]  wdata;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic [8:0]  prog_counter;
  logic        halted;
  logic [15:0] last_instr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  toy_cpu_step_executor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .addr(addr), .wdata(wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .prog_counter(prog_counter),
    .halted(halted), .last_instr(last_instr),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Machine state mirror
  logic [7:0] mem_img [tcse_pkg::MemDepth];
  logic [7:0] regs_img [tcse_pkg::RegCount];
  logic [8:0] pc_img;
  logic       halt_img;
  logic [7:0] start_img;

  req_t pending_reqs[$];
  res_t expected_beats[$];
  int   errors;
  int   cycles;
  int   in_idle_pct;
  int   out_idle_pct;
  int   steps_run;
  int   results_seen;
  bit   hold_in;

  localparam int Limit = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] mem_rd(input int a);
    return (a < tcse_pkg::MemDepth) ? mem_img[a] : 8'h00;
  endfunction

  function automatic int fval(input logic [7:0] b);
    int mag;
    mag = int'(b[3:0]) << b[6:4];
    return b[7] ? -mag : mag;
  endfunction

  // Float add: exact sum, smallest exponent, truncate, saturate.
  function automatic logic [7:0] fadd(input logic [7:0] a, input logic [7:0] b);
    int sum;
    int mag;
    int e;
    logic sgn;
    sum = fval(a) + fval(b);
    sgn = (sum < 0);
    mag = (sum < 0) ? -sum : sum;
    e = 0;
    if (mag == 0) return 8'h00;
    while ((mag >> e) > 15) e++;
    if (e > 7) return {sgn, 7'h7F};
    return {sgn, 3'(e), 4'(mag >> e)};
  endfunction

  function automatic logic [7:0] ror8(input logic [7:0] v, input int n);
    n = n & 7;
    if (n == 0) return v;
    return 8'((16'(v) >> n) | (16'(v) << (8 - n)));
  endfunction

  function automatic logic [15:0] exec_instr();
    logic [7:0] b0;
    logic [7:0] b1;
    logic [3:0] r;
    logic [3:0] s;
    logic [3:0] t;
    int nxt;
    b0 = mem_rd(pc_img);
    b1 = mem_rd(pc_img + 1);
    r = b0[3:0];
    s = b1[7:4];
    t = b1[3:0];
    nxt = pc_img + 2;
    if (nxt > 256) nxt = 256;
    case (b0[7:4])
      tcse_pkg::OP_LOAD:  regs_img[r] = mem_rd(b1);
      tcse_pkg::OP_LDI:   regs_img[r] = b1;
      tcse_pkg::OP_STORE: mem_img[b1] = regs_img[r];
      tcse_pkg::OP_MOVE:  regs_img[t] = regs_img[s];
      tcse_pkg::OP_ADDI:  regs_img[r] = regs_img[s] + regs_img[t];
      tcse_pkg::OP_ADDF:  regs_img[r] = fadd(regs_img[s], regs_img[t]);
      tcse_pkg::OP_OR:    regs_img[r] = regs_img[s] | regs_img[t];
      tcse_pkg::OP_AND:   regs_img[r] = regs_img[s] & regs_img[t];
      tcse_pkg::OP_XOR:   regs_img[r] = regs_img[s] ^ regs_img[t];
      tcse_pkg::OP_ROR:   regs_img[r] = ror8(regs_img[r], b1);
      tcse_pkg::OP_JMP:   if (regs_img[0] == regs_img[r]) nxt = b1;
      tcse_pkg::OP_HALT:  halt_img = 1'b1;
      tcse_pkg::OP_ROL:   regs_img[r] = ror8(regs_img[r], 8 - (b1 & 7));
      default: ;
    endcase
    pc_img = 9'(nxt);
    return {b0, b1};
  endfunction

  function automatic res_t machine_step(input req_t q);
    res_t o;
    o.read_data = 8'h00;
    o.last_instr = 16'h0000;
    case (q.req_type)
      tcse_pkg::REQ_STEP:
        if (!halt_img && pc_img < tcse_pkg::MemDepth) o.last_instr = exec_instr();
      tcse_pkg::REQ_MEM_WR: mem_img[q.addr] = q.wdata;
      tcse_pkg::REQ_MEM_RD: o.read_data = mem_rd(q.addr);
      tcse_pkg::REQ_REG_RD: o.read_data = regs_img[q.addr[3:0]];
      tcse_pkg::REQ_RESTART: begin
        pc_img = {1'b0, start_img};
        halt_img = 1'b0;
      end
      default: ;
    endcase
    o.prog_counter = pc_img;
    o.halted = halt_img || pc_img >= tcse_pkg::MemDepth;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // Driver: one beat in flight on the input channel
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_beats.push_back(machine_step('{req_type, addr, wdata}));
        if (req_type == tcse_pkg::REQ_STEP) steps_run++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !hold_in &&
            $urandom_range(99) >= in_idle_pct) begin
          req_t q;
          q = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= q.req_type;
          addr <= q.addr;
          wdata <= q.wdata;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat against the oldest prediction
  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("toy_cpu_step_executor regression: fail");
      $finish;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", last_instr, 0);
        end else begin
          res_t e;
          e = expected_beats.pop_front();
          if (read_data !== e.read_data) report_mismatch("read_data", read_data, e.read_data);
          if (prog_counter !== e.prog_counter)
            report_mismatch("prog_counter", prog_counter, e.prog_counter);
          if (halted !== e.halted) report_mismatch("halted", halted, e.halted);
          if (last_instr !== e.last_instr)
            report_mismatch("last_instr", last_instr, e.last_instr);
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic queue_req(input logic [2:0] rt, input logic [7:0] a, input logic [7:0] w);
    pending_reqs.push_back('{rt, a, w});
  endtask

  // Wait until every queued beat is through and predictions drained.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    start_img = v;
    @(posedge clk);
  endtask

  // Random program: instruction pairs written at base, then a restart, steps, a register read and a memory read.
  task automatic queue_program(input logic [7:0] base, input int n_instr);
    logic [7:0] b0;
    logic [7:0] b1;
    for (int i = 0; i < n_instr; i++) begin
      b0 = 8'($urandom);
      b1 = 8'($urandom);
      if ($urandom_range(9) < 3) b0[7:4] = tcse_pkg::OP_LDI;
      if (b0[7:4] == tcse_pkg::OP_HALT && $urandom_range(3) != 0) b0[7:4] = tcse_pkg::OP_ADDF;
      if (b0[7:4] == tcse_pkg::OP_JMP && $urandom_range(1))
        b1 = base + 8'($urandom_range(2 * n_instr));
      queue_req(tcse_pkg::REQ_MEM_WR, base + 8'(2 * i), b0);
      queue_req(tcse_pkg::REQ_MEM_WR, base + 8'(2 * i + 1), b1);
    end
    queue_req(tcse_pkg::REQ_RESTART, 8'($urandom), 8'($urandom));
    for (int i = 0; i < n_instr + 2; i++)
      queue_req(tcse_pkg::REQ_STEP, 8'($urandom), 8'($urandom));
    queue_req(tcse_pkg::REQ_REG_RD, 8'($urandom), 8'h00);
    queue_req(tcse_pkg::REQ_MEM_RD, 8'($urandom), 8'h00);
  endtask

  int total;
  int n_prog;
  logic [7:0] base;

  initial begin
    for (int i = 0; i < tcse_pkg::MemDepth; i++) mem_img[i] = 8'h00;
    for (int i = 0; i < tcse_pkg::RegCount; i++) regs_img[i] = 8'h00;
    pc_img = 9'd0;
    halt_img = 1'b0;
    start_img = 8'h00;
    errors = 0;
    cycles = 0;
    steps_run = 0;
    results_seen = 0;
    hold_in = 1'b0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    req_type = tcse_pkg::REQ_STEP;
    addr = 8'h00;
    wdata = 8'h00;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: program at 0xF0 runs to end of memory; ops and float corners.
    write_start(8'hF0);
    queue_req(tcse_pkg::REQ_MEM_WR, 8'hF0, 8'h21); queue_req(tcse_pkg::REQ_MEM_WR, 8'hF1, 8'h7F);
    queue_req(tcse_pkg::REQ_MEM_WR, 8'hF2, 8'h22); queue_req(tcse_pkg::REQ_MEM_WR, 8'hF3, 8'h7F);
    queue_req(tcse_pkg::REQ_MEM_WR, 8'hF4, 8'h63); queue_req(tcse_pkg::REQ_MEM_WR, 8'hF5, 8'h12);
    queue_req(tcse_pkg::REQ_MEM_WR, 8'hF6, 8'hA3); queue_req(tcse_pkg::REQ_MEM_WR, 8'hF7, 8'hFB);
    queue_req(tcse_pkg::REQ_MEM_WR, 8'hF8, 8'hD3); queue_req(tcse_pkg::REQ_MEM_WR, 8'hF9, 8'h08);
    queue_req(tcse_pkg::REQ_MEM_WR, 8'hFE, 8'h2A); queue_req(tcse_pkg::REQ_MEM_WR, 8'hFF, 8'hFF);
    queue_req(tcse_pkg::REQ_RESTART, 8'h00, 8'h00);
    repeat (9) queue_req(tcse_pkg::REQ_STEP, 8'h00, 8'h00);  // last one finds pc at 256
    queue_req(tcse_pkg::REQ_REG_RD, 8'hF3, 8'h00);
    queue_req(tcse_pkg::REQ_REG_RD, 8'h0A, 8'h00);
    queue_req(tcse_pkg::REQ_MEM_RD, 8'hFF, 8'h00);
    queue_req(ReqSpareLo, 8'hFF, 8'hFF);
    queue_req(ReqSpareHi, 8'h00, 8'h00);
    drain();

    // Halt, then a step that must do nothing.
    write_start(8'h00);
    queue_req(tcse_pkg::REQ_MEM_WR, 8'h00, 8'hC0);
    queue_req(tcse_pkg::REQ_RESTART, 8'h00, 8'h00);
    queue_req(tcse_pkg::REQ_STEP, 8'h00, 8'h00);
    queue_req(tcse_pkg::REQ_STEP, 8'h00, 8'h00);
    drain();

    // Random phases, new start address each time
    total = 0;
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 48 : 0;
      out_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 28 : 0;
      while (total < (ph + 1) * 272) begin
        base = (ph == 2 && $urandom_range(3) == 0) ? 8'hF8 : 8'($urandom_range(200));
        write_start(base);
        if ($urandom_range(4) == 0) begin
          repeat (6) queue_req(3'($urandom), 8'($urandom), 8'($urandom));
          total += 6;
        end else begin
          n_prog = $urandom_range(2, 6);
          queue_program(base, n_prog);
          total += 3 * n_prog + 5;
        end
        if (ph == 1 && total < 400) begin
          // sender holds off until the block is fully drained
          hold_in = 1'b1;
          while (expected_beats.size() > 0 || in_valid) @(posedge clk);
          hold_in = 1'b0;
        end
        drain();
      end
    end

    write_start(8'hFF);
    queue_req(tcse_pkg::REQ_RESTART, 8'h00, 8'h00);
    queue_req(tcse_pkg::REQ_STEP, 8'h00, 8'h00);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d result beats, %0d step requests, 3 idle mixes",
             results_seen, steps_run);
    if (errors == 0) begin
      $display("toy_cpu_step_executor regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("toy_cpu_step_executor regression: fail");
    end
    $finish;
  end

endmodule
